[hw/rtl/sebr_pkg.sv]
// Shared types, widths and codes for the spectral energy band ratio block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package sebr_pkg;

    // Sizing of the spectrum stream and the accumulators.
    localparam int MAX_BINS   = 4096;
    localparam int MAG_W      = 16;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int ACC_W      = 44;
    localparam int IDX_W      = 13;
    localparam int NORM_W     = 17;
    localparam int THR_W      = 32;
    localparam int RATIO_W    = 17;
    localparam int STATUS_W   = 2;
    localparam int PROD_W     = NORM_W + IDX_W;
    localparam int EDGE_W     = PROD_W + 1 - 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Job queue between the accumulation front and the divider back.
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QLVL_W     = QPTR_W + 1;

    // Divider step counter.
    localparam int CNT_W      = $clog2(RATIO_W);

    localparam logic [ACC_W-1:0]   ACC_MAX   = {ACC_W{1'b1}};
    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(65536);
    localparam logic [IDX_W-1:0]   IDX_MAX   = {IDX_W{1'b1}};

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SILENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ORDER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LENGTH = 2'd3;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             last_bin;
    } item_t;

    typedef struct packed {
        logic [RATIO_W-1:0]  ratio;
        logic [STATUS_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic [IDX_W-1:0]  bin_count;
        logic [NORM_W-1:0] start_norm;
        logic [NORM_W-1:0] stop_norm;
        logic [THR_W-1:0]  silence_threshold;
    } cfg_t;

    // One finished frame waiting for its division.
    typedef struct packed {
        logic [ACC_W-1:0]    band;
        logic [ACC_W-1:0]    total;
        logic [STATUS_W-1:0] status;
    } job_t;

endpackage

`default_nettype wire

[hw/rtl/sebr_front.sv]
// Front part: takes spectrum bins, classifies them against the band edges,
// squares and accumulates them, and hands one job per frame to the queue.
// Depends on sebr_pkg.
`default_nettype none

module sebr_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  sebr_pkg::item_t            item,
    output logic                       full,
    input  sebr_pkg::cfg_t             cfg,
    input  logic [sebr_pkg::QLVL_W-1:0] q_level,
    output logic                       job_push,
    output sebr_pkg::job_t             job
);
    import sebr_pkg::*;

    logic                accept;
    logic [IDX_W-1:0]    n_eff;
    logic [IDX_W-1:0]    n_m1;
    logic [PROD_W:0]     start_sum;
    logic [PROD_W:0]     stop_sum;
    logic [EDGE_W-1:0]   start_edge;
    logic [EDGE_W:0]     stop_raw;
    logic [EDGE_W:0]     stop_edge;
    logic                in_band;
    logic [IDX_W:0]      frame_len;
    logic [STATUS_W-1:0] pre_status;
    logic [QLVL_W+1:0]   pending;

    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                s1_valid_reg;
    logic [MAG_W-1:0]    s1_mag_reg;
    logic                s1_band_reg;
    logic                s1_last_reg;
    logic [STATUS_W-1:0] s1_status_reg;
    logic                s2_valid_reg;
    logic [SQ_W-1:0]     s2_sq_reg;
    logic                s2_band_reg;
    logic                s2_last_reg;
    logic [STATUS_W-1:0] s2_status_reg;
    logic [ACC_W-1:0]    total_reg, total_next;
    logic [ACC_W-1:0]    band_reg, band_next;
    logic [ACC_W:0]      total_sum;
    logic [ACC_W:0]      band_sum;

    // Frames still on their way to the queue count against its free space.
    assign pending = (QLVL_W+2)'(q_level)
                   + (QLVL_W+2)'(s1_valid_reg & s1_last_reg)
                   + (QLVL_W+2)'(s2_valid_reg & s2_last_reg);
    assign full    = (pending >= (QLVL_W+2)'(QDEPTH));
    assign accept  = push & ~full;

    // Effective bin count, clamped to the supported range.
    always_comb
    begin
        if (cfg.bin_count == '0)
            n_eff = IDX_W'(1);
        else if (cfg.bin_count > IDX_W'(MAX_BINS))
            n_eff = IDX_W'(MAX_BINS);
        else
            n_eff = cfg.bin_count;
    end

    // Band edges rounded to the nearest bin; stop is one past the band.
    assign n_m1       = n_eff - IDX_W'(1);
    assign start_sum  = (PROD_W+1)'(cfg.start_norm) * (PROD_W+1)'(n_m1)
                      + (PROD_W+1)'(32768);
    assign stop_sum   = (PROD_W+1)'(cfg.stop_norm) * (PROD_W+1)'(n_m1)
                      + (PROD_W+1)'(32768);
    assign start_edge = start_sum[PROD_W:16];
    assign stop_raw   = {1'b0, stop_sum[PROD_W:16]} + (EDGE_W+1)'(1);
    assign stop_edge  = (stop_raw > (EDGE_W+1)'(n_eff)) ? (EDGE_W+1)'(n_eff) : stop_raw;

    assign in_band = ((EDGE_W)'(idx_reg) >= start_edge)
                   && ((EDGE_W+1)'(idx_reg) < stop_edge);

    // Error status of a frame, settled when its last bin arrives.
    assign frame_len = {1'b0, idx_reg} + (IDX_W+1)'(1);
    always_comb
    begin
        if (cfg.stop_norm < cfg.start_norm)
            pre_status = ST_ORDER;
        else if (frame_len != {1'b0, n_eff})
            pre_status = ST_LENGTH;
        else
            pre_status = ST_OK;
    end

    // Bin index within the frame, saturating on over-long frames.
    always_comb
    begin
        idx_next = idx_reg;
        if (accept)
        begin
            if (item.last_bin)
                idx_next = '0;
            else if (idx_reg != IDX_MAX)
                idx_next = idx_reg + IDX_W'(1);
        end
    end

    // Saturating accumulation of the squared bins.
    assign total_sum = {1'b0, total_reg} + (ACC_W+1)'(s2_sq_reg);
    assign band_sum  = {1'b0, band_reg} + (ACC_W+1)'(s2_sq_reg);

    always_comb
    begin
        total_next = total_reg;
        band_next  = band_reg;
        if (s2_valid_reg)
        begin
            total_next = total_sum[ACC_W] ? ACC_MAX : total_sum[ACC_W-1:0];
            if (s2_band_reg)
                band_next = band_sum[ACC_W] ? ACC_MAX : band_sum[ACC_W-1:0];
        end
    end

    // A frame's last bin pushes its sums and clears the accumulators.
    assign job_push   = s2_valid_reg & s2_last_reg;
    assign job.band   = band_next;
    assign job.total  = total_next;
    assign job.status = s2_status_reg;

    // Control state of the two pipeline stages and the accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            total_reg    <= '0;
            band_reg     <= '0;
        end
        else
        begin
            idx_reg      <= idx_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            if (job_push)
            begin
                total_reg <= '0;
                band_reg  <= '0;
            end
            else
            begin
                total_reg <= total_next;
                band_reg  <= band_next;
            end
        end
    end

    // Stage payloads: classified bin, then its square.
    always_ff @(posedge clk)
    begin
        s1_mag_reg    <= item.magnitude;
        s1_band_reg   <= in_band;
        s1_last_reg   <= item.last_bin;
        s1_status_reg <= pre_status;
        s2_sq_reg     <= SQ_W'(s1_mag_reg) * SQ_W'(s1_mag_reg);
        s2_band_reg   <= s1_band_reg;
        s2_last_reg   <= s1_last_reg;
        s2_status_reg <= s1_status_reg;
    end

endmodule

`default_nettype wire

[hw/rtl/sebr_queue.sv]
// Short job queue between the accumulation front and the divider back.
// Depends on sebr_pkg.
`default_nettype none

module sebr_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  sebr_pkg::job_t              wr_job,
    input  logic                        rd_en,
    output sebr_pkg::job_t              rd_job,
    output logic [sebr_pkg::QLVL_W-1:0] level
);
    import sebr_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QLVL_W-1:0] level_reg, level_next;

    assign rd_job = mem_reg[rd_ptr_reg];
    assign level  = level_reg;

    // Fill level follows pushes and pops.
    always_comb
    begin
        level_next = level_reg;
        if (wr_en && !rd_en)
            level_next = level_reg + QLVL_W'(1);
        else if (!wr_en && rd_en)
            level_next = level_reg - QLVL_W'(1);
    end

    // Pointers and level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            level_reg <= level_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

`default_nettype wire

[hw/rtl/sebr_back.sv]
// Back part: takes one job per frame, decides its status and divides band
// by total energy one quotient bit a cycle; holds the result for the reader.
// Depends on sebr_pkg.
`default_nettype none

module sebr_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [sebr_pkg::THR_W-1:0] threshold,
    input  logic                       job_valid,
    input  sebr_pkg::job_t             job,
    output logic                       job_pop,
    input  logic                       pop,
    output logic                       empty,
    output sebr_pkg::result_t          result
);
    import sebr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]          state_reg, state_next;
    job_t                job_reg, job_next;
    logic [ACC_W:0]      rem_reg, rem_next;
    logic [RATIO_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic                silent;
    logic                geq;
    logic [ACC_W:0]      rem_after;
    logic                load;

    assign silent = (job_reg.total <= ACC_W'(threshold)) || (job_reg.total == '0);

    // One restoring division step.
    assign geq       = (rem_reg >= {1'b0, job_reg.total});
    assign rem_after = geq ? (rem_reg - {1'b0, job_reg.total}) : rem_reg;

    // Sequencer: take a job, classify it, divide, deliver.
    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        job_pop     = 1'b0;
        load        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    job_next   = job;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                quo_next = '0;
                if (job_reg.status != ST_OK)
                begin
                    status_next = job_reg.status;
                    state_next  = S_DONE;
                end
                else if (silent)
                begin
                    status_next = ST_SILENT;
                    state_next  = S_DONE;
                end
                else
                begin
                    status_next = ST_OK;
                    rem_next    = {1'b0, job_reg.band};
                    cnt_next    = CNT_W'(RATIO_W - 1);
                    state_next  = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = {rem_after[ACC_W-1:0], 1'b0};
                quo_next = {quo_reg[RATIO_W-2:0], geq};
                if (cnt_reg == '0)
                    state_next = S_DONE;
                else
                    cnt_next = cnt_reg - CNT_W'(1);
            end
            S_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output slot: a finished result waits here until it is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg & ~pop;
        out_next       = out_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_next.status = status_reg;
            out_next.ratio  = (quo_reg > RATIO_ONE) ? RATIO_ONE : quo_reg;
        end
    end

    assign empty  = ~out_valid_reg;
    assign result = out_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

endmodule

`default_nettype wire

[hw/rtl/spectral_energy_band_ratio.sv]
// Top level of the spectral energy band ratio block: configuration registers,
// accumulation front, job queue and divider back. Depends on sebr_pkg.
//
// Usage. Spectrum bins enter as requests on the input queue port (push/full),
// one unsigned Q0.16 magnitude per request, last_bin marking the end of a
// frame. One request per clock is taken while full is low. Each frame yields
// one result (ratio, status) on the output queue port (empty/pop).
// Result path: when the divider is free, an ok frame's last bin goes through
// the square-and-accumulate pipeline into the job queue; the back then takes
// the job, classifies it, forms 17 quotient bits at one bit per cycle and
// loads the output slot. A frame with an error or silent status skips the
// division. Throughput: one bin per cycle while full is low; for short
// frames the shared bit-serial divider, which finishes one frame before it
// takes the next, sets the lower bound on the time per frame.
// Stalls: up to 4 finished frames wait in the job queue; full rises once the
// queued frames and the frames still in the two pipeline stages reach 4. A
// result that is not popped holds the divider, and bins keep streaming
// until the queue fills. Reset clears the queue, the accumulators and the
// bin index; registers return to bin_count 1024, start 0, stop 297 and
// threshold 0. Registers are written through cfg_write/cfg_index/cfg_data.
`default_nettype none

module spectral_energy_band_ratio (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  sebr_pkg::item_t                 item,
    output logic                            full,
    output logic                            empty,
    input  logic                            pop,
    output sebr_pkg::result_t               result,
    input  logic                            cfg_write,
    input  logic [sebr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sebr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sebr_pkg::*;

    cfg_t              cfg_reg, cfg_next;
    logic              job_push;
    job_t              job_in;
    logic              job_pop;
    job_t              job_head;
    logic [QLVL_W-1:0] q_level;

    // Configuration register file.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BIN_COUNT: cfg_next.bin_count         = cfg_data[IDX_W-1:0];
                REG_START:     cfg_next.start_norm        = cfg_data[NORM_W-1:0];
                REG_STOP:      cfg_next.stop_norm         = cfg_data[NORM_W-1:0];
                REG_THRESHOLD: cfg_next.silence_threshold = cfg_data[THR_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bin_count         <= IDX_W'(1024);
            cfg_reg.start_norm        <= '0;
            cfg_reg.stop_norm         <= NORM_W'(297);
            cfg_reg.silence_threshold <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Accumulation front.
    sebr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .cfg      (cfg_reg),
        .q_level  (q_level),
        .job_push (job_push),
        .job      (job_in)
    );

    // Job queue.
    sebr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (job_in),
        .rd_en  (job_pop),
        .rd_job (job_head),
        .level  (q_level)
    );

    // Divider back.
    sebr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (cfg_reg.silence_threshold),
        .job_valid (q_level != '0),
        .job       (job_head),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

`ifndef SYNTH
    // The front never pushes a frame into a queue that has no room for it.
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> ((q_level < QLVL_W'(QDEPTH)) || job_pop))
        else $error("job queue overflow");

    // The back only takes a job that is there.
    a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (q_level != '0))
        else $error("job queue underflow");

    // Any status other than ok carries a zero ratio.
    a_error_ratio_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.status != ST_OK)) |-> (result.ratio == '0))
        else $error("non-zero ratio with error status");

    // A ratio never exceeds one.
    a_ratio_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.ratio <= RATIO_ONE))
        else $error("ratio above one");
`endif

endmodule

`default_nettype wire

[sim/tb_spectral_energy_band_ratio.sv]
`timescale 1ns / 1ps
// Testbench for spectral_energy_band_ratio: streams spectrum frames through the request
// queue, predicts each frame's band ratio and status, and checks every result.
// Depends on sebr_pkg and the spectral_energy_band_ratio RTL.

module tb_spectral_energy_band_ratio;
    import sebr_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_BINS   = 1350;

    typedef enum int {MAG_ANY, MAG_QUIET, MAG_FULL, MAG_ZERO, MAG_SPARSE} mag_style_e;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    item_t                 item;
    logic                  full;
    logic                  empty;
    logic                  pop;
    result_t               result;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Bins still to be offered, and frame results the block still owes.
    item_t   bins_pending[$];
    result_t ratios_due[$];
    result_t ratio_owed;

    // Register copy and running frame state of the prediction.
    cfg_t             band_setting;
    logic [IDX_W-1:0] frame_pos;
    logic [ACC_W-1:0] total_sum;
    logic [ACC_W-1:0] band_sum;

    int send_idle_pct;
    int recv_idle_pct;
    int rx_hold_left;
    int errors;
    int bins_taken;
    int frames_checked;
    int settings_used;
    int random_bins;
    int status_seen[4];
    bit pressure_done;

    spectral_energy_band_ratio dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Effective bin count: the register clamped to the supported range.
    function automatic logic [63:0] clamp_bins(logic [IDX_W-1:0] count);
        if (count == 0)
            return 64'd1;
        if (count > MAX_BINS)
            return 64'(MAX_BINS);
        return 64'(count);
    endfunction

    function automatic logic [ACC_W-1:0] add_sat(logic [ACC_W-1:0] acc, logic [63:0] sq);
        logic [63:0] sum;
        sum = 64'(acc) + sq;
        return (sum > 64'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
    endfunction

    // Accumulate one accepted bin; on the last bin of a frame, queue its result.
    function automatic void accumulate_bin(item_t bin);
        logic [63:0] n;
        logic [63:0] start_bin;
        logic [63:0] stop_bin;
        logic [63:0] sq;
        logic [63:0] quot;
        result_t     r;
        n = clamp_bins(band_setting.bin_count);
        start_bin = (64'(band_setting.start_norm) * (n - 1) + 64'd32768) >> 16;
        stop_bin = ((64'(band_setting.stop_norm) * (n - 1) + 64'd32768) >> 16) + 1;
        if (stop_bin > n)
            stop_bin = n;
        sq = 64'(bin.magnitude) * 64'(bin.magnitude);
        total_sum = add_sat(total_sum, sq);
        if (64'(frame_pos) >= start_bin && 64'(frame_pos) < stop_bin)
            band_sum = add_sat(band_sum, sq);
        if (!bin.last_bin)
        begin
            if (frame_pos != IDX_MAX)
                frame_pos = frame_pos + 1'b1;
            return;
        end
        // Order error beats length mismatch, which beats silence.
        r.ratio = '0;
        if (band_setting.stop_norm < band_setting.start_norm)
            r.status = ST_ORDER;
        else if (64'(frame_pos) + 1 != n)
            r.status = ST_LENGTH;
        else if (64'(total_sum) <= 64'(band_setting.silence_threshold) || total_sum == 0)
            r.status = ST_SILENT;
        else
        begin
            r.status = ST_OK;
            quot = {4'b0, band_sum, 16'b0} / 64'(total_sum);
            r.ratio = (quot > 64'(RATIO_ONE)) ? RATIO_ONE : quot[RATIO_W-1:0];
        end
        ratios_due.push_back(r);
        frame_pos = '0;
        total_sum = '0;
        band_sum = '0;
    endfunction

    function automatic logic [MAG_W-1:0] draw_magnitude(mag_style_e style);
        case (style)
            MAG_QUIET:  return MAG_W'($urandom_range(0, 255));
            MAG_FULL:   return '1;
            MAG_ZERO:   return '0;
            MAG_SPARSE: return ($urandom_range(0, 7) == 0) ? MAG_W'($urandom) : '0;
            default:    return MAG_W'($urandom);
        endcase
    endfunction

    function automatic mag_style_e pick_style();
        case ($urandom_range(0, 7))
            4:       return MAG_QUIET;
            5:       return MAG_FULL;
            6:       return MAG_ZERO;
            7:       return MAG_SPARSE;
            default: return MAG_ANY;
        endcase
    endfunction

    function automatic logic [NORM_W-1:0] draw_norm();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return NORM_W'(65536);
            3:       return NORM_W'($urandom);
            default: return NORM_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // Write all four registers on successive cycles; the block is idle meanwhile.
    task automatic apply_setting(logic [IDX_W-1:0] count, logic [NORM_W-1:0] start_val,
                                 logic [NORM_W-1:0] stop_val, logic [THR_W-1:0] thr);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_BIN_COUNT;
        cfg_data  <= CFG_DATA_W'(count);
        @(negedge clk);
        cfg_index <= REG_START;
        cfg_data  <= CFG_DATA_W'(start_val);
        @(negedge clk);
        cfg_index <= REG_STOP;
        cfg_data  <= CFG_DATA_W'(stop_val);
        @(negedge clk);
        cfg_index <= REG_THRESHOLD;
        cfg_data  <= CFG_DATA_W'(thr);
        @(negedge clk);
        cfg_write <= 1'b0;
        band_setting.bin_count = count;
        band_setting.start_norm = start_val;
        band_setting.stop_norm = stop_val;
        band_setting.silence_threshold = thr;
        settings_used++;
    endtask

    task automatic queue_frame(int len, mag_style_e style);
        item_t b;
        for (int i = 0; i < len; i++)
        begin
            b.magnitude = draw_magnitude(style);
            b.last_bin = (i == len - 1);
            bins_pending.push_back(b);
        end
    endtask

    // Wait until every pending bin is sent and every owed result has come, then let the pipeline settle.
    task automatic drain();
        while (bins_pending.size() != 0 || ratios_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One random register setting followed by a handful of frames, mostly well formed.
    task automatic random_phase();
        logic [IDX_W-1:0]  count;
        logic [NORM_W-1:0] lo;
        logic [NORM_W-1:0] hi;
        logic [NORM_W-1:0] swap;
        logic [THR_W-1:0]  thr;
        logic [63:0]       n;
        int                frames;
        int                len;
        case ($urandom_range(0, 11))
            0:       count = '0;
            1:       count = 13'd1;
            2:       count = 13'd4096;
            3:       count = '1;
            4:       count = IDX_W'($urandom_range(25, 80));
            default: count = IDX_W'($urandom_range(2, 24));
        endcase
        lo = draw_norm();
        hi = draw_norm();
        if (hi < lo && $urandom_range(0, 99) < 85)
        begin
            swap = lo;
            lo = hi;
            hi = swap;
        end
        case ($urandom_range(0, 7))
            0:       thr = '1;
            1:       thr = THR_W'($urandom);
            2, 3:    thr = THR_W'($urandom_range(0, 1 << 20));
            default: thr = '0;
        endcase
        apply_setting(count, lo, hi, thr);
        n = clamp_bins(count);
        frames = $urandom_range(3, 12);
        for (int f = 0; f < frames; f++)
        begin
            // Large bin counts only see short, mismatched frames to keep the run brief.
            if (n > 300)
                len = $urandom_range(1, 40);
            else if ($urandom_range(0, 99) < 80)
                len = int'(n);
            else
                len = $urandom_range(1, int'(n) + 3);
            queue_frame(len, pick_style());
            random_bins += len;
        end
        drain();
    endtask

    // Sender: offer the oldest pending bin unless idling this cycle.
    always @(negedge clk)
    begin
        if (rst_n && bins_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
        begin
            push <= 1'b1;
            item <= bins_pending[0];
        end
        else
            push <= 1'b0;
    end

    // Sender: an accepted request feeds the prediction and leaves the queue.
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            accumulate_bin(item);
            void'(bins_pending.pop_front());
            bins_taken++;
        end
    end

    // Receiver: pop at random, or hold off entirely while a hold-off is running.
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (rx_hold_left > 0)
        begin
            pop <= 1'b0;
            rx_hold_left--;
        end
        else
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Receiver: compare each accepted result with the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            frames_checked++;
            status_seen[result.status]++;
            if (ratios_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, actual ratio %0d status %0d",
                         $time, result.ratio, result.status);
            end
            else
            begin
                ratio_owed = ratios_due.pop_front();
                if (result.ratio !== ratio_owed.ratio || result.status !== ratio_owed.status)
                begin
                    errors++;
                    $display("%0t: mismatch, expected ratio %0d status %0d, actual ratio %0d status %0d",
                             $time, ratio_owed.ratio, ratio_owed.status,
                             result.ratio, result.status);
                end
            end
        end
    end

    // Watchdog: end the run when no request moves on either side for too long.
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("tb_spectral_energy_band_ratio: FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        pop = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        band_setting.bin_count = 13'd1024;
        band_setting.start_norm = '0;
        band_setting.stop_norm = NORM_W'(297);
        band_setting.silence_threshold = '0;
        frame_pos = '0;
        total_sum = '0;
        band_sum = '0;
        send_idle_pct = 31;
        recv_idle_pct = 79;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Four-bin frames over the whole band: full scale, silence, short and long frames.
        apply_setting(13'd4, '0, NORM_W'(65536), '0);
        queue_frame(4, MAG_FULL);
        queue_frame(4, MAG_ZERO);
        queue_frame(2, MAG_ANY);
        queue_frame(1, MAG_FULL);
        queue_frame(5, MAG_ANY);
        drain();

        // A zero bin count acts as one bin; a full-scale bin stays under the top threshold.
        apply_setting('0, '0, '0, '1);
        queue_frame(1, MAG_FULL);
        drain();

        // The band starts past the last bin, so the ratio is zero.
        apply_setting(13'd4, '1, '1, '0);
        queue_frame(4, MAG_ANY);
        drain();

        // Stop below start wins over the length mismatch of this frame.
        apply_setting(13'd4, NORM_W'(40000), NORM_W'(20000), '0);
        queue_frame(3, MAG_ANY);
        drain();

        // A long frame with its band in the middle, then an overlong full-scale one.
        apply_setting(13'd200, NORM_W'(16384), NORM_W'(49152), '0);
        queue_frame(200, MAG_ANY);
        drain();
        apply_setting(13'd100, '0, '1, '0);
        queue_frame(140, MAG_FULL);
        drain();

        // Random part in three idling regimes, with one receiver hold-off in the last.
        while (random_bins < RANDOM_BINS)
        begin
            if (random_bins >= 2 * RANDOM_BINS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (random_bins >= RANDOM_BINS / 3)
            begin
                send_idle_pct = 79;
                recv_idle_pct = 31;
            end
            if (!pressure_done && random_bins >= 2 * RANDOM_BINS / 3)
            begin
                // Short frames pile up behind a stalled receiver until full rises.
                apply_setting(13'd3, '0, NORM_W'(65536), '0);
                @(posedge clk);
                rx_hold_left = 500;
                for (int f = 0; f < 120; f++)
                    queue_frame(3, MAG_ANY);
                random_bins += 360;
                pressure_done = 1'b1;
                drain();
            end
            else
                random_phase();
        end

        $display("Run covered %0d bins in %0d frames over %0d register settings.",
                 bins_taken, frames_checked, settings_used);
        $display("Statuses seen: %0d ok, %0d silent, %0d stop below start, %0d length mismatch.",
                 status_seen[ST_OK], status_seen[ST_SILENT], status_seen[ST_ORDER],
                 status_seen[ST_LENGTH]);
        if (errors == 0)
            $display("tb_spectral_energy_band_ratio: PASS");
        else
            $display("tb_spectral_energy_band_ratio: FAIL");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/sebr_pkg.sv
hw/rtl/sebr_front.sv
hw/rtl/sebr_queue.sv
hw/rtl/sebr_back.sv
hw/rtl/spectral_energy_band_ratio.sv
sim/tb_spectral_energy_band_ratio.sv
